>>> rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    // Operation codes carried on the input channel.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // Longest code that the table keeps; code_bits carries at most CODE_W bits.
    localparam int EFF_MAX_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Table address width and the first symbol value outside the table.
    localparam int TBL_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

    // Packing window: up to seven pending bits followed by one full code.
    localparam int WIN_W = CODE_W + BYTE_W;
    localparam int CNT_W = $clog2(WIN_W);

    // Job queue between the front and the packer.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One job for the packer: a flush, or a code left-aligned in CODE_W bits.
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code_left;
        logic [LEN_W-1:0]  len;
    } t_job;

endpackage

>>> rtl/core/hcbp_queue.sv
module hcbp_queue
    import hcbp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_job            i_push_job,
    input  logic            i_pop,
    output t_job            o_head_job,
    output logic            o_empty,
    output logic [Q_CW-1:0] o_count
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wp;
    logic [Q_AW-1:0] n_rp;
    logic [Q_CW-1:0] n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    assign o_head_job = r_mem[r_rp];
    assign o_empty    = (r_count == '0);
    assign o_count    = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("job queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CW'(Q_DEPTH)) |-> (!i_push || i_pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job popped from an empty queue");

endmodule

>>> rtl/core/hcbp_front.sv
module hcbp_front
    import hcbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_operation,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_code_bits,
    input  logic [LEN_W-1:0]  i_code_length,
    input  logic [Q_CW-1:0]   i_q_count,
    output logic              o_push,
    output t_job              o_job
);

    logic [CODE_W-1:0] r_code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]  r_len_mem  [SYMBOL_COUNT];

    logic [CODE_W-1:0] r_rd_code;
    logic [LEN_W-1:0]  r_rd_len;
    logic              r_a_vld;
    logic              r_a_flush;

    logic              accept;
    logic              sym_ok;
    logic [TBL_AW-1:0] idx;
    logic [LEN_W-1:0]  sat_len;
    logic [Q_CW:0]     occupancy;
    logic [LEN_W-1:0]  align_sh;

    assign sym_ok  = ({1'b0, i_symbol} < SYM_LIMIT);
    assign idx     = i_symbol[TBL_AW-1:0];
    assign sat_len = (i_code_length > LEN_W'(EFF_MAX_LEN)) ? LEN_W'(EFF_MAX_LEN)
                                                           : i_code_length;

    // Room is reserved for the item in the lookup stage as well as the queued ones.
    assign occupancy = (Q_CW + 1)'(i_q_count) + (Q_CW + 1)'(r_a_vld);
    assign o_stall   = (occupancy >= (Q_CW + 1)'(Q_DEPTH));
    assign accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == OP_LOAD) && sym_ok) begin
            r_code_mem[idx] <= i_code_bits;
            r_len_mem[idx]  <= sat_len;
        end
        if (accept) begin
            r_rd_code <= r_code_mem[idx];
            r_rd_len  <= r_len_mem[idx];
            r_a_flush <= (i_operation == OP_FLUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept && (((i_operation == OP_ENCODE) && sym_ok)
                                  || (i_operation == OP_FLUSH));
        end
    end

    // Left-align the code; shifting by CODE_W - len also drops excess high bits.
    assign align_sh = LEN_W'(CODE_W) - r_rd_len;

    always_comb begin
        o_push          = r_a_vld;
        o_job.flush     = r_a_flush;
        o_job.code_left = r_a_flush ? '0 : (r_rd_code << align_sh);
        o_job.len       = r_a_flush ? '0 : r_rd_len;
    end

endmodule

>>> rtl/core/hcbp_back.sv
module hcbp_back
    import hcbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    logic              r_busy;
    logic [WIN_W-1:0]  r_win;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_acc;
    logic [2:0]        r_pcnt;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              n_busy;
    logic [WIN_W-1:0]  n_win;
    logic [CNT_W-1:0]  n_cnt;
    logic [BYTE_W-1:0] n_acc;
    logic [2:0]        n_pcnt;
    logic              n_out_vld;
    logic [BYTE_W-1:0] n_out_byte;
    logic              n_out_last;

    logic              out_free;
    logic [WIN_W-1:0]  head_win;
    logic [CNT_W-1:0]  head_cnt;
    logic              cur_vld;
    logic [WIN_W-1:0]  cur_win;
    logic [CNT_W-1:0]  cur_cnt;
    logic              has_byte;
    logic [CNT_W-1:0]  rem_cnt;
    logic [WIN_W-1:0]  rem_win;
    logic              fin;
    logic              emit;

    assign out_free = !r_out_vld || !i_stall;

    // The pending bits sit left-aligned in r_acc with zeros below them, so a
    // flush is simply a window of one byte when anything is pending.
    always_comb begin
        if (i_job.flush) begin
            head_win = {r_acc, {CODE_W{1'b0}}};
            head_cnt = (r_pcnt != 3'd0) ? CNT_W'(BYTE_W) : '0;
        end else begin
            head_win = {r_acc, {CODE_W{1'b0}}}
                     | ({i_job.code_left, {BYTE_W{1'b0}}} >> r_pcnt);
            head_cnt = CNT_W'(r_pcnt) + CNT_W'(i_job.len);
        end
    end

    assign cur_vld  = r_busy || !i_q_empty;
    assign cur_win  = r_busy ? r_win : head_win;
    assign cur_cnt  = r_busy ? r_cnt : head_cnt;
    assign has_byte = (cur_cnt >= CNT_W'(BYTE_W));
    assign rem_cnt  = cur_cnt - CNT_W'(BYTE_W);
    assign rem_win  = cur_win << BYTE_W;
    assign fin      = (rem_cnt < CNT_W'(BYTE_W));
    assign emit     = cur_vld && has_byte && out_free;
    assign o_pop    = !r_busy && !i_q_empty && (!has_byte || out_free);

    always_comb begin
        n_busy     = r_busy;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_pcnt     = r_pcnt;
        n_out_vld  = r_out_vld && i_stall;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        if (emit) begin
            n_out_vld  = 1'b1;
            n_out_byte = cur_win[WIN_W-1 -: BYTE_W];
            n_out_last = fin;
            if (fin) begin
                n_busy = 1'b0;
                n_acc  = rem_win[WIN_W-1 -: BYTE_W];
                n_pcnt = rem_cnt[2:0];
            end else begin
                n_busy = 1'b1;
                n_win  = rem_win;
                n_cnt  = rem_cnt;
            end
        end else if (cur_vld && !has_byte) begin
            n_acc  = cur_win[WIN_W-1 -: BYTE_W];
            n_pcnt = cur_cnt[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_acc     <= '0;
            r_pcnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_acc     <= n_acc;
            r_pcnt    <= n_pcnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_cnt      <= n_cnt;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid    = r_out_vld;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    a_busy_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt >= CNT_W'(BYTE_W)))
        else $error("packer busy without a full byte in the window");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_job.flush) |=> (r_pcnt == 3'd0 && r_acc == '0))
        else $error("accumulator not cleared after a flush");

    a_busy_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !fin) |=> r_busy)
        else $error("packer dropped a job with bytes left");

endmodule

>>> rtl/core/huffman_code_bit_packer.sv
// Huffman encoder back end: code table plus MSB-first bit packer.
// Input channel (i_valid / o_stall) carries one operation per transfer:
// load writes a table entry, encode looks up a symbol and packs its code,
// flush pads the partial byte with zeros and sends it. Output channel
// (o_valid / i_stall) carries one packed byte per transfer; o_last marks
// the final byte produced by an input item. Loads, empty flushes and
// encodes that complete no byte produce no output transfer.
// An item passes the table read register, the job queue and the output
// register on its way to o_valid. Throughput is one item per cycle while
// each item yields at most one byte and the receiver does not stall; an
// item yielding several bytes holds the packer until all are sent, as it
// emits one byte per cycle while the receiver does not stall. The front
// keeps accepting until the lookup stage and the four-entry job queue
// together hold four jobs, then raises o_stall.
// Reset clears the bit accumulator, the queue and all valid flags; the
// code table is not cleared and must be loaded before symbols are encoded.
// When the receiver stalls, the output byte holds and the packer waits.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_operation,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [CODE_W-1:0] i_code_bits,
    input  logic [LEN_W-1:0]  i_code_length,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    // Jobs handed from the lookup front to the packer.
    logic            push;
    t_job            push_job;
    logic            pop;
    t_job            head_job;
    logic            q_empty;
    logic [Q_CW-1:0] q_count;

    // The front owns the code table and left-aligns each looked-up code.
    hcbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Short queue so that output backpressure does not stall lookups at once.
    hcbp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head_job (head_job),
        .o_empty    (q_empty),
        .o_count    (q_count)
    );

    // The packer merges codes into the accumulator and emits whole bytes.
    hcbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
